// ----- sv/free_page_stack_allocator_top_assert.svh -----
// Assertion macros used by the page allocator control module.
`ifndef FREE_PAGE_STACK_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_PAGE_STACK_ALLOCATOR_TOP_ASSERT_SVH

// Invariant that must hold at every clock edge outside reset.
`define FPSA_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("page allocator invariant violated");

// Consequence that must hold in the cycle after the antecedent.
`define FPSA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page allocator state update violated");

`endif

// ----- sv/fpsa_pkg.sv -----
// Package with types and constants of the free page stack allocator.
`timescale 1ns / 1ps
package fpsa_pkg;

	localparam int STACK_ENTRIES_DEF = 4096;
	localparam int ENTRIES_PER_EXT_DEF = 1024;
	localparam int ADDR_W = 32;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
	localparam int STATUS_W = 3;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_PAGING_ENABLED = 1'b0,
		CFG_START_ADDRESS  = 1'b1
	} cfg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_OOM        = 3'd1,
		ST_IGNORED    = 3'd2,
		ST_STACK_PAGE = 3'd3,
		ST_DROPPED    = 3'd4
	} status_t;

	// Result of one request as decided in the control stage.
	typedef struct packed {
		logic              pop;
		logic [ADDR_W-1:0] address;
		status_t           status;
	} fpsa_res_t;

endpackage

// ----- sv/fpsa_if.sv -----
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface fpsa_req_if
	import fpsa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [ADDR_W-1:0] page_address;

	modport source (output valid, cmd, page_address, input ready);
	modport sink (input valid, cmd, page_address, output ready);
endinterface

interface fpsa_rsp_if
	import fpsa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   result_address;
	logic [STATUS_W-1:0] status;

	modport source (output valid, result_address, status, input ready);
	modport sink (input valid, result_address, status, output ready);
endinterface

// ----- sv/fpsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fpsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- sv/fpsa_ctrl.sv -----
// Allocator control: configuration, stack pointers, bump counter and decision.
`timescale 1ns / 1ps
`include "free_page_stack_allocator_top_assert.svh"
module fpsa_ctrl
	import fpsa_pkg::*;
#(
	parameter int STACK_ENTRIES = STACK_ENTRIES_DEF,
	parameter int ENTRIES_PER_EXT = ENTRIES_PER_EXT_DEF,
	localparam int CW = $clog2(STACK_ENTRIES + 1),
	localparam int AW = $clog2(STACK_ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_wdata,
	input  logic              accept,
	input  logic              cmd,
	input  logic [ADDR_W-1:0] page_address,
	output fpsa_res_t         res,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic              ram_re,
	output logic [AW-1:0]     ram_raddr
);
	logic                  paging_q;
	logic [ADDR_W-1:0]     start_q;
	logic [CW-1:0]         depth_q, depth_d;
	logic [CW-1:0]         cap_q, cap_d;
	logic [PAGE_NUM_W-1:0] bump_q, bump_d;
	logic [PAGE_NUM_W-1:0] bump_hi;
	logic [CW-1:0]         depth_m1;
	logic                  grow_over;

	// Page number of the current bump address: base page is start page + 1.
	assign bump_hi = start_q[ADDR_W-1:PAGE_SHIFT] + PAGE_NUM_W'(1) + bump_q;
	assign depth_m1 = depth_q - CW'(1);
	assign grow_over = (32'(cap_q) + 32'(ENTRIES_PER_EXT)) > 32'(STACK_ENTRIES);
	assign ram_raddr = depth_m1[AW-1:0];
	assign ram_waddr = depth_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q <= 1'b0;
			start_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PAGING_ENABLED: paging_q <= cfg_wdata[0];
				CFG_START_ADDRESS:  start_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		depth_d = depth_q;
		cap_d = cap_q;
		bump_d = bump_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		res.pop = 1'b0;
		res.address = '0;
		res.status = ST_OK;
		if (accept) begin
			if (cmd_t'(cmd) == CMD_ALLOC) begin
				if (paging_q) begin
					if (depth_q == '0 || 32'(depth_q) > 32'(STACK_ENTRIES)) begin
						res.status = ST_OOM;
					end else begin
						depth_d = depth_m1;
						ram_re = 1'b1;
						res.pop = 1'b1;
					end
				end else begin
					// Return the address after the advance.
					bump_d = bump_q + PAGE_NUM_W'(1);
					res.address = {bump_hi + PAGE_NUM_W'(1), PAGE_SHIFT'(0)};
				end
			end else begin
				priority if (page_address < {bump_hi, PAGE_SHIFT'(0)}) begin
					res.status = ST_IGNORED;
				end else if (cap_q <= depth_q) begin
					if (grow_over) begin
						res.status = ST_DROPPED;
					end else begin
						cap_d = cap_q + CW'(ENTRIES_PER_EXT);
						res.status = ST_STACK_PAGE;
					end
				end else if (32'(depth_q) < 32'(STACK_ENTRIES)) begin
					ram_we = 1'b1;
					depth_d = depth_q + CW'(1);
				end else begin
					res.status = ST_DROPPED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			cap_q <= '0;
			bump_q <= '0;
		end else begin
			depth_q <= depth_d;
			cap_q <= cap_d;
			bump_q <= bump_d;
		end
	end

	`FPSA_ASSERT_ALWAYS(a_depth_in_cap, depth_q <= cap_q)
	`FPSA_ASSERT_ALWAYS(a_cap_bound, 32'(cap_q) <= 32'(STACK_ENTRIES))
	`FPSA_ASSERT_ALWAYS(a_one_ram_op, !(ram_we && ram_re))
	`FPSA_ASSERT_NEXT(a_push_grows, ram_we, depth_q == $past(depth_q) + CW'(1))
	`FPSA_ASSERT_NEXT(a_pop_shrinks, ram_re, depth_q == $past(depth_q) - CW'(1))
endmodule

// ----- sv/free_page_stack_allocator_top.sv -----
// Free page stack allocator: one page request per cycle unless the response stalls, registered result.
// Each accepted request is decided in the cycle it is accepted and its response
// appears on the next cycle; a new request can be taken every cycle as long as
// the response side keeps taking beats, so throughput is one request per clock.
// Each request makes at most one stack access, a push write or pop read of the
// free-page RAM, whose read data is registered in the RAM. A stalled
// response holds the request channel. Stack RAM contents are not cleared after
// reset: only entries that were pushed are ever popped, so no clearing pass is
// needed and the block is ready right out of reset. Configuration writes are
// expected only while no request is in flight.
`timescale 1ns / 1ps
module free_page_stack_allocator_top
	import fpsa_pkg::*;
#(
	parameter int STACK_ENTRIES = STACK_ENTRIES_DEF,
	parameter int ENTRIES_PER_EXT = ENTRIES_PER_EXT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_wdata,
	fpsa_req_if.sink          req,
	fpsa_rsp_if.source        rsp
);
	localparam int AW = $clog2(STACK_ENTRIES);

	fpsa_res_t         res;
	logic              accept;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [ADDR_W-1:0] ram_rdata;
	logic              valid_s1;
	logic              pop_s1;
	logic [ADDR_W-1:0] address_s1;
	status_t           status_s1;

	// Advance when the response slot is empty or being drained.
	assign req.ready = !valid_s1 || rsp.ready;
	assign accept = req.valid && req.ready;

	fpsa_ctrl #(
		.STACK_ENTRIES  (STACK_ENTRIES),
		.ENTRIES_PER_EXT(ENTRIES_PER_EXT)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.cmd         (req.cmd),
		.page_address(req.page_address),
		.res         (res),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr)
	);

	fpsa_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(STACK_ENTRIES)
	) u_stack_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req.page_address),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Payload holds while stalled; RAM read data holds since reads fire only on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1 <= res.pop;
			address_s1 <= res.address;
			status_s1 <= res.status;
		end
	end

	assign rsp.valid = valid_s1;
	assign rsp.result_address = pop_s1 ? ram_rdata : address_s1;
	assign rsp.status = status_s1;
endmodule
